// ----- rtl/ltsc_pkg.sv -----
// ----------------------------------------------------------------------------
// ltsc_pkg
// Shared types and constants for the language tag structure checker: the
// subtag phase codes, the per-tag state record and the byte constants.
// ----------------------------------------------------------------------------
package ltsc_pkg;

  // Byte that separates subtags.
  localparam logic [7:0] SEPARATOR  = 8'h2D;

  // The subtag length counter stops at this value, which fits no class.
  localparam logic [3:0] LENGTH_CAP = 4'd9;

  // Where the parser stands in the tag grammar.
  typedef enum logic [2:0] {
    PH_LANG         = 3'd0,
    PH_AFTER_LANG   = 3'd1,
    PH_AFTER_SCRIPT = 3'd2,
    PH_AFTER_REGION = 3'd3
  } phase_t;

  // Everything the checker remembers between bytes of one tag.
  typedef struct packed {
    phase_t     tag_phase;
    logic [3:0] subtag_length;
    logic       only_letters;
    logic       only_digits;
    logic       only_alnum;
    logic       starts_with_digit;
    logic       verdict_settled;
    logic       settled_value;
  } state_t;

  // State at reset and at the start of every new tag.
  localparam state_t STATE_RESET = '{
    tag_phase:         PH_LANG,
    subtag_length:     4'd0,
    only_letters:      1'b1,
    only_digits:       1'b1,
    only_alnum:        1'b1,
    starts_with_digit: 1'b0,
    verdict_settled:   1'b0,
    settled_value:     1'b0
  };

endpackage

// ----- rtl/ltsc_step.sv -----
// ----------------------------------------------------------------------------
// ltsc_step
// Combinational update for one tag byte: classifies the byte, extends the
// current subtag, closes it on a separator or the final byte, and advances
// the grammar phase or fixes the verdict.
// ----------------------------------------------------------------------------
module ltsc_step (
  input  ltsc_pkg::state_t state,
  input  logic [7:0]       char_code,
  input  logic             last_char,
  output ltsc_pkg::state_t state_next,
  output logic             tag_valid
);

  logic             letter;
  logic             digit;
  logic             is_sep;
  logic             closing;
  ltsc_pkg::state_t taken;
  ltsc_pkg::state_t closed;
  logic             c_lang;
  logic             c_single;
  logic             c_script;
  logic             c_region;
  logic             c_variant;
  logic             len_2_3;
  logic             len_5_8;

  // Byte classes; only ASCII letters and digits count.
  assign letter = ((char_code >= 8'h41) && (char_code <= 8'h5A)) ||
                  ((char_code >= 8'h61) && (char_code <= 8'h7A));
  assign digit  = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign is_sep = (char_code == ltsc_pkg::SEPARATOR);
  assign closing = is_sep || last_char;

  // Extend the current subtag with a non-separator byte until the verdict is fixed.
  always_comb begin
    taken = state;
    if (!is_sep && !state.verdict_settled) begin
      if (state.subtag_length == 4'd0) begin
        taken.starts_with_digit = digit;
      end
      taken.only_letters = state.only_letters & letter;
      taken.only_digits  = state.only_digits & digit;
      taken.only_alnum   = state.only_alnum & (letter | digit);
      if (state.subtag_length < ltsc_pkg::LENGTH_CAP) begin
        taken.subtag_length = state.subtag_length + 4'd1;
      end
    end
  end

  // Subtag classes by length and character content.
  assign len_2_3   = (taken.subtag_length == 4'd2) || (taken.subtag_length == 4'd3);
  assign len_5_8   = (taken.subtag_length >= 4'd5) && (taken.subtag_length <= 4'd8);
  assign c_lang    = (len_2_3 || len_5_8) && taken.only_letters;
  assign c_single  = (taken.subtag_length == 4'd1) && taken.only_alnum;
  assign c_script  = (taken.subtag_length == 4'd4) && taken.only_letters;
  assign c_region  = ((taken.subtag_length == 4'd2) && taken.only_letters) ||
                     ((taken.subtag_length == 4'd3) && taken.only_digits);
  assign c_variant = ((taken.subtag_length == 4'd4) && taken.starts_with_digit &&
                      taken.only_alnum) || (len_5_8 && taken.only_alnum);

  // Close the subtag: advance the phase or fix the verdict.
  always_comb begin
    closed = taken;
    if (closing && !taken.verdict_settled) begin
      case (taken.tag_phase)
        ltsc_pkg::PH_LANG: begin
          if (c_lang) begin
            closed.tag_phase = ltsc_pkg::PH_AFTER_LANG;
          end else begin
            closed.verdict_settled = 1'b1;
            closed.settled_value   = 1'b0;
          end
        end
        ltsc_pkg::PH_AFTER_LANG: begin
          if (c_single) begin
            closed.verdict_settled = 1'b1;
            closed.settled_value   = 1'b1;
          end else if (c_script) begin
            closed.tag_phase = ltsc_pkg::PH_AFTER_SCRIPT;
          end else if (c_region || c_variant) begin
            closed.tag_phase = ltsc_pkg::PH_AFTER_REGION;
          end else begin
            closed.verdict_settled = 1'b1;
            closed.settled_value   = 1'b0;
          end
        end
        ltsc_pkg::PH_AFTER_SCRIPT: begin
          if (c_single) begin
            closed.verdict_settled = 1'b1;
            closed.settled_value   = 1'b1;
          end else if (c_region || c_variant) begin
            closed.tag_phase = ltsc_pkg::PH_AFTER_REGION;
          end else begin
            closed.verdict_settled = 1'b1;
            closed.settled_value   = 1'b0;
          end
        end
        default: begin
          // After a region or variant; unused codes behave the same way.
          if (c_single) begin
            closed.verdict_settled = 1'b1;
            closed.settled_value   = 1'b1;
          end else if (c_variant) begin
            closed.tag_phase = ltsc_pkg::PH_AFTER_REGION;
          end else begin
            closed.verdict_settled = 1'b1;
            closed.settled_value   = 1'b0;
          end
        end
      endcase
    end
  end

  // Verdict for a final byte: a tag that was never rejected is valid.
  assign tag_valid = closed.verdict_settled ? closed.settled_value : 1'b1;

  // A separator starts a new subtag; the final byte starts a new tag.
  always_comb begin
    state_next = closed;
    if (is_sep) begin
      state_next.subtag_length     = 4'd0;
      state_next.only_letters      = 1'b1;
      state_next.only_digits       = 1'b1;
      state_next.only_alnum        = 1'b1;
      state_next.starts_with_digit = 1'b0;
    end
    if (last_char) begin
      state_next = ltsc_pkg::STATE_RESET;
    end
  end

endmodule

// ----- rtl/language_tag_structure_checker.sv -----
// ----------------------------------------------------------------------------
// language_tag_structure_checker
// Checks the structure of a language tag streamed one byte per request and
// reports on the final byte whether the tag is well formed.
// ----------------------------------------------------------------------------
// Usage:
//   The char channel (char_valid/char_ready) carries one byte of the tag per
//   request in char_code, with last_char set on the final byte. The verdict
//   channel (verdict_valid/verdict_ready) carries one request per tag, with
//   tag_valid high for a well formed tag. Non-final bytes give no verdict.
//   A byte is taken into an input register and processed from there by the
//   per-byte update logic; a final byte's verdict lands in the output
//   register, and verdict_valid rises once the update stage passes that byte.
//   Throughput is one byte per cycle, set by the combinational update between
//   the input register and the tag state register, but for the hold below.
//   While a verdict waits in the output register, bytes keep flowing until a
//   further final byte reaches the update stage; that byte then holds there
//   and char_ready drops until the waiting verdict is taken.
//   Reset clears all valid flags and puts the tag state at the start of a
//   new tag. After each final byte the state returns there by itself.
// ----------------------------------------------------------------------------
module language_tag_structure_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       verdict_valid,
  input  logic       verdict_ready,
  output logic       tag_valid
);

  logic             s1_valid;
  logic [7:0]       s1_char;
  logic             s1_last;
  logic             s1_fire;
  logic             out_free;
  ltsc_pkg::state_t state;
  ltsc_pkg::state_t state_next;
  logic             verdict_next;

  // The update stage moves on unless a final byte meets a full output register that is not being read.
  assign out_free   = !verdict_valid || verdict_ready;
  assign s1_fire    = s1_valid && (!s1_last || out_free);
  assign char_ready = !s1_valid || s1_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_ready) begin
      s1_valid <= char_valid;
    end
    if (char_ready && char_valid) begin
      s1_char <= char_code;
      s1_last <= last_char;
    end
  end

  // Per-byte grammar update.
  ltsc_step u_step (
    .state      (state),
    .char_code  (s1_char),
    .last_char  (s1_last),
    .state_next (state_next),
    .tag_valid  (verdict_next)
  );

  // Tag state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ltsc_pkg::STATE_RESET;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  // Output register for the verdict.
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      verdict_valid <= 1'b1;
    end else if (verdict_ready) begin
      verdict_valid <= 1'b0;
    end
    if (s1_fire && s1_last) begin
      tag_valid <= verdict_next;
    end
  end

  // After a final byte the state is back at the start of a tag.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> state.tag_phase == ltsc_pkg::PH_LANG &&
      state.subtag_length == 4'd0 && !state.verdict_settled)
    else $error("tag state not restarted after final byte");

  // The subtag length never passes its cap.
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    state.subtag_length <= ltsc_pkg::LENGTH_CAP)
    else $error("subtag length above cap");

  // A final byte blocked by a waiting verdict stays in the update stage.
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last && verdict_valid && !verdict_ready |=>
      s1_valid && s1_last && $stable(state))
    else $error("blocked final byte lost");

  // A fixed verdict only changes by starting a new tag.
  a_settled: assert property (@(posedge clk) disable iff (rst)
    state.verdict_settled && !(s1_fire && s1_last) |=>
      state.verdict_settled && $stable(state.settled_value))
    else $error("settled verdict changed mid-tag");

endmodule
